>>> sv/itp_pkg.sv
// Shared constants, register codes and the blend-weight table function.
package itp_pkg;

    localparam int ITP_COS_BITS_DEF  = 8;
    localparam int ITP_FRAC_BITS_DEF = 8;

    localparam int ELEV_W  = 15;
    localparam int TEMP_W  = 16;
    localparam int LAPSE_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int WGT_W   = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TEMP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAPSE_RATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_STR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_THICK  = 3'd4;

    localparam logic signed [TEMP_W-1:0]  RST_BASE_TEMP  = 16'sd0;
    localparam logic signed [LAPSE_W-1:0] RST_LAPSE_RATE = 17'sd426;
    localparam logic signed [TEMP_W-1:0]  RST_INV_STR    = 16'sd1280;
    localparam logic signed [ELEV_W-1:0]  RST_INV_BOT    = 15'sd0;
    localparam logic signed [ELEV_W-1:0]  RST_INV_THICK  = 15'sd0;

    localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    typedef struct packed {
        logic be;
        logic above;
        logic below;
    } t_side;

    // Weight (1 + cos(pi*k/2^tbits))/2 in Q16, evaluated at elaboration.
    function automatic logic [WGT_W-1:0] blend_weight(input int unsigned k,
                                                      input int unsigned tbits);
        logic [63:0] full;
        logic [63:0] j;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] prod;
        logic [63:0] w30;
        logic        neg;
        int          i;
        full = 64'd1 << tbits;
        neg  = ((64'(k) << 1) > full);
        j    = neg ? full - 64'(k) : 64'(k);
        x    = (PI_Q30 * j) >> tbits;
        x2   = (x * x) >> 30;
        t    = Q30_ONE;
        for (i = 0; i < 6; i++) begin
            prod = (x2 * t) >> 30;
            case (i)
                0:       p = prod / 64'd132;
                1:       p = prod / 64'd90;
                2:       p = prod / 64'd56;
                3:       p = prod / 64'd30;
                4:       p = prod / 64'd12;
                default: p = prod / 64'd2;
            endcase
            t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        end
        w30 = neg ? Q30_ONE - t : Q30_ONE + t;
        w30 = (w30 + (64'd1 << 14)) >> 15;
        return w30[WGT_W-1:0];
    endfunction

endpackage

>>> sv/itp_in_if.sv
// Input channel: one elevation item with its batch-end mark.
interface itp_in_if import itp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [ELEV_W-1:0] elevation;
    logic                     batch_end_in;

    modport source (output valid, output elevation, output batch_end_in, input ready);
    modport sink   (input valid, input elevation, input batch_end_in, output ready);
endinterface

>>> sv/itp_out_if.sv
// Output channel: one modeled temperature item with its batch-end mark.
interface itp_out_if import itp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] profile_temperature;
    logic                     batch_end_out;

    modport source (output valid, output profile_temperature, output batch_end_out,
                    input ready);
    modport sink   (input valid, input profile_temperature, input batch_end_out,
                    output ready);
endinterface

>>> sv/inversion_temperature_profile.sv
// Pipelined temperature profile with a raised-cosine inversion layer.
//
//  channel   dir  handshake          payload
//  i_item    in   valid/ready        elevation[14:0] s, batch_end_in
//  o_item    out  valid/ready        profile_temperature[15:0] s, batch_end_out
//  i_cfg_*   in   write enable only  index[2:0], data[16:0]
//
// One item per cycle while the output is not stalled, through COSINE_TABLE_BITS+7
// register stages, most of them in the restoring divider that resolves one phase-index
// bit per stage. Reset clears the stage valid bits, loads the register defaults and
// holds the input off. Each stage holds while its successor is full and blocked;
// empty stages close up, so input is taken while a result waits at the output.
module inversion_temperature_profile import itp_pkg::*; #(
    parameter int COSINE_TABLE_BITS  = ITP_COS_BITS_DEF,
    parameter int TEMP_FRACTION_BITS = ITP_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    itp_in_if.sink                i_item,
    itp_out_if.source             o_item
);

    localparam int B      = COSINE_TABLE_BITS;
    localparam int KW     = B + 1;
    localparam int ROM_N  = (1 << B) + 1;
    localparam int RW     = B + 16;
    localparam int SUM_W  = TEMP_FRACTION_BITS + 34;
    localparam int SHW    = SUM_W - 16;
    localparam int ST_DIV = 2;
    localparam int ST_W   = ST_DIV + KW;
    localparam int ST_M   = ST_W + 1;
    localparam int ST_S   = ST_M + 1;
    localparam int ST_O   = ST_S + 1;
    localparam int NS     = ST_O + 1;
    localparam logic [KW-1:0] K_MAX = KW'(1 << B);

    // configuration
    logic signed [TEMP_W-1:0]  r_base;
    logic signed [LAPSE_W-1:0] r_lapse;
    logic signed [TEMP_W-1:0]  r_str;
    logic signed [ELEV_W-1:0]  r_bot;
    logic signed [ELEV_W-1:0]  r_thick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE_TEMP;
            r_lapse <= RST_LAPSE_RATE;
            r_str   <= RST_INV_STR;
            r_bot   <= RST_INV_BOT;
            r_thick <= RST_INV_THICK;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASE_TEMP:  r_base  <= i_cfg_data[TEMP_W-1:0];
                CFG_LAPSE_RATE: r_lapse <= i_cfg_data[LAPSE_W-1:0];
                CFG_INV_STR:    r_str   <= i_cfg_data[TEMP_W-1:0];
                CFG_INV_BOT:    r_bot   <= i_cfg_data[ELEV_W-1:0];
                CFG_INV_THICK:  r_thick <= i_cfg_data[ELEV_W-1:0];
                default: ;
            endcase
        end
    end

    // layer span and divisor follow the static configuration
    logic [ELEV_W-1:0]        w_span;
    logic [ELEV_W:0]          w_div;
    logic signed [ELEV_W+1:0] w_top;
    logic signed [ELEV_W:0]   w_d;

    assign w_span = r_thick[ELEV_W-1] ? ELEV_W'(-r_thick) : ELEV_W'(r_thick);
    assign w_div  = {w_span, 1'b0};
    assign w_top  = (ELEV_W+2)'(r_bot) + $signed({2'b00, w_span});
    assign w_d    = (ELEV_W+1)'(i_item.elevation) - (ELEV_W+1)'(r_bot);

    // weight table
    logic [WGT_W-1:0] w_rom [ROM_N];
    for (genvar g = 0; g < ROM_N; g++) begin : g_rom
        assign w_rom[g] = blend_weight(g, B);
    end

    // stage handshake
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_item.ready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign i_item.ready = i_rst_n && en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_item.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // stage 1: capture, offset into the layer, region flags
    logic signed [ELEV_W-1:0] r_s1_z;
    logic [ELEV_W-1:0]        r_s1_d;
    t_side                    r_s1_side;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_z          <= i_item.elevation;
            r_s1_d          <= w_d[ELEV_W-1:0];
            r_s1_side.be    <= i_item.batch_end_in;
            r_s1_side.above <= (ELEV_W+2)'(i_item.elevation) >= w_top;
            r_s1_side.below <= i_item.elevation <= r_bot;
        end
    end

    // stage 2: lapse product, dividend
    logic signed [31:0] r_s2_gz;
    logic [RW-1:0]      r_s2_rem;
    t_side              r_s2_side;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s2_gz   <= 32'(r_lapse) * 32'(r_s1_z);
            r_s2_rem  <= (r_s1_side.above || r_s1_side.below) ? '0 :
                         RW'({r_s1_d, {KW{1'b0}}}) + RW'(w_span);
            r_s2_side <= r_s1_side;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [RW-1:0]      r_dv_rem  [KW];
    logic [KW-1:0]      r_dv_q    [KW];
    logic signed [31:0] r_dv_gz   [KW];
    t_side              r_dv_side [KW];

    for (genvar s = 0; s < KW; s++) begin : g_div
        localparam int BIT = KW - 1 - s;
        logic [RW-1:0]      rem_in;
        logic [KW-1:0]      q_in;
        logic signed [31:0] gz_in;
        t_side              side_in;
        logic [RW:0]        sub;

        if (s == 0) begin : g_first
            assign rem_in  = r_s2_rem;
            assign q_in    = '0;
            assign gz_in   = r_s2_gz;
            assign side_in = r_s2_side;
        end else begin : g_next
            assign rem_in  = r_dv_rem[s-1];
            assign q_in    = r_dv_q[s-1];
            assign gz_in   = r_dv_gz[s-1];
            assign side_in = r_dv_side[s-1];
        end

        assign sub = {1'b0, rem_in} - ((RW+1)'(w_div) << BIT);

        always_ff @(posedge i_clk) begin
            if (en[ST_DIV+s]) begin
                r_dv_rem[s]  <= sub[RW] ? rem_in : sub[RW-1:0];
                r_dv_q[s]    <= {q_in[KW-2:0], ~sub[RW]};
                r_dv_gz[s]   <= gz_in;
                r_dv_side[s] <= side_in;
            end
        end
    end

    // weight lookup
    logic [KW-1:0]      w_k;
    logic [WGT_W-1:0]   r_w_w;
    logic signed [31:0] r_w_gz;
    logic               r_w_be;

    assign w_k = (r_dv_q[KW-1] > K_MAX) ? K_MAX : r_dv_q[KW-1];

    always_ff @(posedge i_clk) begin
        if (en[ST_W]) begin
            if (r_dv_side[KW-1].above) begin
                r_w_w <= '0;
            end else if (r_dv_side[KW-1].below) begin
                r_w_w <= WGT_ONE;
            end else begin
                r_w_w <= w_rom[w_k];
            end
            r_w_gz <= r_dv_gz[KW-1];
            r_w_be <= r_dv_side[KW-1].be;
        end
    end

    // inversion product
    logic signed [TEMP_W+WGT_W:0] r_m_aw;
    logic signed [31:0]           r_m_gz;
    logic                         r_m_be;

    always_ff @(posedge i_clk) begin
        if (en[ST_M]) begin
            r_m_aw <= (TEMP_W+WGT_W+1)'(r_str) * $signed({1'b0, r_w_w});
            r_m_gz <= r_w_gz;
            r_m_be <= r_w_be;
        end
    end

    // exact sum in units of 2^-(F+16) K
    logic signed [SUM_W-1:0] r_s_sum;
    logic                    r_s_be;

    always_ff @(posedge i_clk) begin
        if (en[ST_S]) begin
            r_s_sum <= (SUM_W'(r_base) <<< 16)
                     - (SUM_W'(r_m_gz) <<< TEMP_FRACTION_BITS)
                     - SUM_W'(r_m_aw);
            r_s_be  <= r_m_be;
        end
    end

    // round half up, saturate
    logic signed [SUM_W-1:0] w_rnd;
    logic signed [SHW-1:0]   w_sh;
    logic signed [TEMP_W-1:0] r_o_temp;
    logic                    r_o_be;

    assign w_rnd = r_s_sum + SUM_W'(32768);
    assign w_sh  = w_rnd[SUM_W-1:16];

    always_ff @(posedge i_clk) begin
        if (en[ST_O]) begin
            if (w_sh > SHW'(32767)) begin
                r_o_temp <= 16'sh7fff;
            end else if (w_sh < -SHW'(32768)) begin
                r_o_temp <= -16'sh8000;
            end else begin
                r_o_temp <= w_sh[TEMP_W-1:0];
            end
            r_o_be <= r_s_be;
        end
    end

    assign o_item.valid               = r_v[NS-1];
    assign o_item.profile_temperature = r_o_temp;
    assign o_item.batch_end_out       = r_o_be;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the inversion temperature profile block.
module tb_top;
    import itp_pkg::*;

    localparam int     TABLE_BITS   = ITP_COS_BITS_DEF;
    localparam int     FRAC_BITS    = ITP_FRAC_BITS_DEF;
    localparam int     PIPE_LATENCY = ITP_COS_BITS_DEF + 7;
    localparam longint CYCLE_LIMIT  = 200000;
    localparam longint TEMP_MAX     = (longint'(1) << (TEMP_W - 1)) - 1;
    localparam longint TEMP_MIN     = -(longint'(1) << (TEMP_W - 1));
    localparam longint ELEV_MAX     = (longint'(1) << (ELEV_W - 1)) - 1;
    localparam longint ELEV_MIN     = -(longint'(1) << (ELEV_W - 1));
    localparam int     UNUSED_IDX_COUNT = (1 << CFG_IDX_W) - 1 - CFG_INV_THICK;
    localparam int     ITEMS_PER_SETTING = 150;
    localparam int     SETTING_COUNT     = 13;

    typedef enum {SET_LOWEST, SET_HIGHEST, SET_TYPICAL, SET_RAW} setting_kind_t;

    typedef struct {
        logic signed [TEMP_W-1:0] temperature;
        logic                     batch_end;
    } temp_item_t;

    class profile_scoreboard;
        longint     base_temp;
        longint     lapse;
        longint     strength;
        longint     bottom;
        longint     thickness;
        temp_item_t expected_q[$];
        int         errors;

        function new();
            base_temp = RST_BASE_TEMP;
            lapse     = RST_LAPSE_RATE;
            strength  = RST_INV_STR;
            bottom    = RST_INV_BOT;
            thickness = RST_INV_THICK;
            errors    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASE_TEMP:  base_temp = longint'($signed(data[TEMP_W-1:0]));
                CFG_LAPSE_RATE: lapse     = longint'($signed(data[LAPSE_W-1:0]));
                CFG_INV_STR:    strength  = longint'($signed(data[TEMP_W-1:0]));
                CFG_INV_BOT:    bottom    = longint'($signed(data[ELEV_W-1:0]));
                CFG_INV_THICK:  thickness = longint'($signed(data[ELEV_W-1:0]));
                default: ;
            endcase
        endfunction

        // Taylor series of cos(x) through x^12 by Horner steps, Q30 in and out
        function longint unsigned cosine_q30(longint unsigned x);
            longint unsigned x2;
            longint unsigned t;
            longint unsigned p;
            int unsigned     divisor [6];
            divisor = '{132, 90, 56, 30, 12, 2};
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            foreach (divisor[i]) begin
                p = ((x2 * t) >> 30) / divisor[i];
                t = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
            end
            return t;
        endfunction

        // Inversion weight in Q16: one below the layer, zero at or above its top
        function longint inversion_weight(longint z);
            longint          span;
            longint          d;
            longint unsigned k;
            longint unsigned j;
            longint unsigned c;
            longint unsigned full;
            logic            upper;
            span = (thickness < 0) ? -thickness : thickness;
            if (z >= bottom + span)
                return 0;
            if (z <= bottom)
                return longint'(WGT_ONE);
            d     = z - bottom;
            k     = ((d << (TABLE_BITS + 1)) + span) / (2 * span);
            full  = 64'd1 << TABLE_BITS;
            upper = (2 * k > full);
            j     = upper ? full - k : k;
            c     = cosine_q30((PI_Q30 * j) >> TABLE_BITS);
            return longint'(((upper ? Q30_ONE - c : Q30_ONE + c) + (64'd1 << 14)) >> 15);
        endfunction

        function logic signed [TEMP_W-1:0] temperature_at(longint z);
            longint total;
            longint r;
            total = base_temp * 65536 - lapse * z * (longint'(1) << FRAC_BITS)
                  - strength * inversion_weight(z);
            // round half up to the output LSB, then clamp
            r = (total + 32768) >>> 16;
            if (r > TEMP_MAX)
                r = TEMP_MAX;
            else if (r < TEMP_MIN)
                r = TEMP_MIN;
            return r[TEMP_W-1:0];
        endfunction

        function void note_elevation(logic signed [ELEV_W-1:0] z, logic be);
            temp_item_t e;
            e.temperature = temperature_at(longint'(z));
            e.batch_end   = be;
            expected_q.push_back(e);
        endfunction

        function void check_temperature(logic signed [TEMP_W-1:0] t, logic be);
            temp_item_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got temperature %0d batch end %0b",
                         $time, t, be);
                return;
            end
            e = expected_q.pop_front();
            if (t !== e.temperature) begin
                errors++;
                $display("%0t: temperature mismatch, expected %0d, got %0d",
                         $time, e.temperature, t);
            end
            if (be !== e.batch_end) begin
                errors++;
                $display("%0t: batch end mismatch, expected %0b, got %0b",
                         $time, e.batch_end, be);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    profile_scoreboard sb = new();

    int     tx_idle_pct  = 21;
    int     rx_idle_pct  = 70;
    int     rx_hold_left = 0;
    longint cycle_count  = 0;

    inversion_temperature_profile dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_ch),
        .o_item      (out_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("inversion_temperature_profile verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_elevation(in_ch.elevation, in_ch.batch_end_in);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_temperature(out_ch.profile_temperature, out_ch.batch_end_out);
    end

    // Receiver: random stalls, or a long hold-off counted down here
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_left > 0) begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_item(logic signed [ELEV_W-1:0] z, logic be);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.elevation    <= z;
        in_ch.batch_end_in <= be;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and wait until every expected item is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        sb.set_register(idx, CFG_DATA_W'(value));
        @(posedge i_clk);
    endtask

    task automatic apply_setting(int t0, int gamma, int depth, int h0, int thick);
        settle();
        // an unused index must leave every register alone
        write_register(CFG_IDX_W'(CFG_INV_THICK + 1 + $urandom_range(UNUSED_IDX_COUNT - 1)),
                       int'($urandom()));
        write_register(CFG_BASE_TEMP, t0);
        write_register(CFG_LAPSE_RATE, gamma);
        write_register(CFG_INV_STR, depth);
        write_register(CFG_INV_BOT, h0);
        write_register(CFG_INV_THICK, thick);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_setting(setting_kind_t kind);
        int thick;
        case (kind)
            SET_LOWEST:  apply_setting(-32768, -65536, -32768, -16384, -16384);
            SET_HIGHEST: apply_setting(32767, 65535, 32767, 16383, 16383);
            SET_TYPICAL: begin
                thick = ($urandom_range(3) == 0) ? int'($urandom_range(1, 6))
                                                 : int'($urandom_range(4000));
                if ($urandom_range(1) == 0)
                    thick = -thick;
                apply_setting(int'($urandom_range(20000)) - 10000,
                              int'($urandom_range(2000)) - 500,
                              int'($urandom_range(8000)) - 4000,
                              int'($urandom_range(11000)) - 1000,
                              thick);
            end
            default: apply_setting(int'($urandom()), int'($urandom()), int'($urandom()),
                                   int'($urandom()), int'($urandom()));
        endcase
    endtask

    // Mostly around the layer, with its edges hit exactly, plus raw patterns
    function automatic logic signed [ELEV_W-1:0] pick_elevation();
        longint span;
        longint lo;
        longint hi;
        longint v;
        int     roll;
        span = (sb.thickness < 0) ? -sb.thickness : sb.thickness;
        lo   = sb.bottom - 8;
        hi   = sb.bottom + span + 8;
        roll = $urandom_range(99);
        if (roll < 30) begin
            v = longint'($signed(ELEV_W'($urandom())));
        end else if (roll < 45) begin
            case ($urandom_range(3))
                0:       v = sb.bottom;
                1:       v = sb.bottom + span;
                2:       v = sb.bottom + 1;
                default: v = sb.bottom + span - 1;
            endcase
        end else begin
            v = lo + longint'($urandom_range(int'(hi - lo)));
        end
        if (v > ELEV_MAX)
            v = ELEV_MAX;
        else if (v < ELEV_MIN)
            v = ELEV_MIN;
        return v[ELEV_W-1:0];
    endfunction

    initial begin
        int            reset_elev [5];
        int            layer_elev [9];
        setting_kind_t kind;
        reset_elev = '{-16384, -1, 0, 1, 16383};
        layer_elev = '{499, 500, 501, 750, 1000, 1250, 1499, 1500, 1501};

        in_ch.valid        <= 1'b0;
        in_ch.elevation    <= '0;
        in_ch.batch_end_in <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_index        <= '0;
        i_cfg_data         <= '0;
        i_rst_n            <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero thickness after reset: the upper rule applies at the bottom
        foreach (reset_elev[i])
            send_item(ELEV_W'(reset_elev[i]), i[0]);

        // negative thickness, layer from 500 m to 1500 m
        apply_setting(5000, 426, 1280, 500, -1000);
        foreach (layer_elev[i])
            send_item(ELEV_W'(layer_elev[i]), i[0]);

        // two metre layer: a single interior point at half phase
        apply_setting(0, 426, 1280, 0, 2);
        send_item(ELEV_W'(0), 1'b0);
        send_item(ELEV_W'(1), 1'b1);
        send_item(ELEV_W'(2), 1'b0);

        // saturation on both sides
        apply_setting(32767, -65536, -32768, -16384, 0);
        send_item(ELEV_W'(16383), 1'b1);
        send_item(ELEV_W'(-16384), 1'b0);
        apply_setting(-32768, 65535, 32767, 0, 0);
        send_item(ELEV_W'(16383), 1'b1);

        for (int s = 0; s < SETTING_COUNT; s++) begin
            if (s == 5) begin
                tx_idle_pct = 70;
                rx_idle_pct = 21;
            end else if (s == 10) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            kind = (s == 1) ? SET_LOWEST : (s == 5) ? SET_HIGHEST :
                   (s % 4 == 3) ? SET_RAW : SET_TYPICAL;
            random_setting(kind);
            // hold the output long enough to back the pipeline up into the input
            if (s == 2)
                rx_hold_left = 300;
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                if (s == 6 && n == ITEMS_PER_SETTING / 2)
                    settle();
                send_item(pick_elevation(), $urandom_range(1));
            end
        end

        settle();
        if (sb.errors == 0)
            $display("inversion_temperature_profile verification clean");
        else
            $display("inversion_temperature_profile verification failed");
        $finish;
    end

endmodule
